// ===== rtl/hfti_pkg.sv =====
// shared types, constants and helper functions for the hex float text parser
`timescale 1ns / 1ps
`default_nettype none
package hfti_pkg;

  localparam int MaxFieldBytesDefault = 255;

  localparam logic [63:0] NA64  = 64'h7FF0_0000_0000_DEAD;
  localparam logic [63:0] NA32  = 64'h0000_0000_7F80_07A2;
  localparam logic [63:0] INF64 = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] INF32 = 64'h0000_0000_7F80_0000;

  localparam logic [11:0] BIAS64 = 12'd1023;
  localparam logic [11:0] BIAS32 = 12'd127;

  localparam logic [3:0] MAX_DIG64 = 4'd13;
  localparam logic [3:0] MAX_DIG32 = 4'd6;

  localparam logic [3:0]  DIG_SAT = 4'd15;
  localparam logic [11:0] EXP_SAT = 12'd4095;

  localparam logic [2:0] NAN_LAST = 3'd2;
  localparam logic [2:0] INF_LAST = 3'd7;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_LEAD  = 4'd1,
    PH_X     = 4'd2,
    PH_MANT  = 4'd3,
    PH_DOT   = 4'd4,
    PH_FRAC  = 4'd5,
    PH_ESIGN = 4'd6,
    PH_EDIG  = 4'd7,
    PH_NAN   = 4'd8,
    PH_INF   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    V_OPEN = 2'd0,
    V_DONE = 2'd1,
    V_FAIL = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    OUT_NUMBER    = 2'd0,
    OUT_NAN       = 2'd1,
    OUT_MALFORMED = 2'd2
  } outcome_t;

  // parse state captured at the field end beat
  typedef struct packed {
    logic        dp;
    logic        fail;
    phase_t      phase;
    logic        negative;
    logic        lz;
    logic [51:0] frac;
    logic [3:0]  ndig;
    logic        eneg;
    logic [11:0] eacc;
    logic [7:0]  count;
  } hfti_fin_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") v = 5'(c - "0");
    else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] nan_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "N";
      3'd1:    ch = "a";
      3'd2:    ch = "N";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] inf_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "I";
      3'd1:    ch = "n";
      3'd2:    ch = "f";
      3'd3:    ch = "i";
      3'd4:    ch = "n";
      3'd5:    ch = "i";
      3'd6:    ch = "t";
      3'd7:    ch = "y";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hfti_scan.sv =====
// per-byte grammar tracker: holds the field state and emits it at the field end
`timescale 1ns / 1ps
`default_nettype none
module hfti_scan #(
  parameter int MAX_FIELD_BYTES = hfti_pkg::MaxFieldBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               beat,
  input  wire logic [7:0]         text_byte,
  input  wire logic               field_end,
  input  wire logic               dp,
  output hfti_pkg::hfti_fin_t     fin
);

  localparam int CountCap = (MAX_FIELD_BYTES < 255) ? MAX_FIELD_BYTES : 255;
  localparam logic [7:0] CAP = 8'(CountCap);

  hfti_pkg::phase_t   phase_r, phase_nxt;
  hfti_pkg::verdict_t verdict_r, verdict_nxt;
  logic        neg_r, neg_nxt;
  logic        lz_r, lz_nxt;
  logic [51:0] frac_r, frac_nxt;
  logic [3:0]  ndig_r, ndig_nxt;
  logic        eneg_r, eneg_nxt;
  logic [11:0] eacc_r, eacc_nxt;
  logic [2:0]  lit_r, lit_nxt;
  logic [7:0]  count_r, count_nxt;

  logic [7:0]  count_inc;
  logic [15:0] exp_sum;
  logic [11:0] exp_sat;
  logic [4:0]  hv;
  logic        is_dig;
  logic        is_p;
  logic        is_sign;
  hfti_pkg::verdict_t verdict_fin;

  always_comb begin
    count_inc = (count_r < CAP) ? count_r + 8'd1 : count_r;
    exp_sum   = ({4'b0, eacc_r} << 3) + ({4'b0, eacc_r} << 1) + {12'b0, text_byte[3:0]};
    exp_sat   = (exp_sum > {4'b0, hfti_pkg::EXP_SAT}) ? hfti_pkg::EXP_SAT : exp_sum[11:0];
    hv        = hfti_pkg::hex_value(text_byte);
    is_dig    = (text_byte >= "0") && (text_byte <= "9");
    is_p      = (text_byte == "p") || (text_byte == "P");
    is_sign   = (text_byte == "-") || (text_byte == "+");

    phase_nxt   = phase_r;
    verdict_nxt = verdict_r;
    neg_nxt     = neg_r;
    lz_nxt      = lz_r;
    frac_nxt    = frac_r;
    ndig_nxt    = ndig_r;
    eneg_nxt    = eneg_r;
    eacc_nxt    = eacc_r;
    lit_nxt     = lit_r;
    count_nxt   = count_r;

    if (verdict_r == hfti_pkg::V_OPEN) begin
      case (phase_r)
        hfti_pkg::PH_START, hfti_pkg::PH_LEAD: begin
          if (phase_r == hfti_pkg::PH_START && is_sign) begin
            neg_nxt   = (text_byte == "-");
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_LEAD;
          end else if (text_byte == "0") begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_X;
          end else if (text_byte == "N") begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_NAN;
            lit_nxt   = 3'd1;
          end else if (text_byte == "I") begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_INF;
            lit_nxt   = 3'd1;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_X: begin
          if (text_byte == "x" || text_byte == "X") begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_MANT;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_MANT: begin
          if (text_byte == "1" || text_byte == "0") begin
            lz_nxt    = (text_byte == "0");
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_DOT;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_DOT: begin
          if (text_byte == ".") begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_FRAC;
          end else if (is_p) begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_ESIGN;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_FRAC: begin
          if (!hv[4]) begin
            frac_nxt  = {frac_r[47:0], hv[3:0]};
            ndig_nxt  = (ndig_r < hfti_pkg::DIG_SAT) ? ndig_r + 4'd1 : ndig_r;
            count_nxt = count_inc;
          end else if (is_p) begin
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_ESIGN;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_ESIGN: begin
          if (is_sign) begin
            eneg_nxt  = (text_byte == "-");
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_EDIG;
          end else if (is_dig) begin
            eacc_nxt  = exp_sat;
            count_nxt = count_inc;
            phase_nxt = hfti_pkg::PH_EDIG;
          end else begin
            verdict_nxt = hfti_pkg::V_DONE;
          end
        end
        hfti_pkg::PH_EDIG: begin
          if (is_dig) begin
            eacc_nxt  = exp_sat;
            count_nxt = count_inc;
          end else begin
            verdict_nxt = hfti_pkg::V_DONE;
          end
        end
        hfti_pkg::PH_NAN: begin
          if (text_byte == hfti_pkg::nan_char(lit_r)) begin
            count_nxt = count_inc;
            if (lit_r == hfti_pkg::NAN_LAST) verdict_nxt = hfti_pkg::V_DONE;
            else lit_nxt = lit_r + 3'd1;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        hfti_pkg::PH_INF: begin
          if (text_byte == hfti_pkg::inf_char(lit_r)) begin
            count_nxt = count_inc;
            if (lit_r == hfti_pkg::INF_LAST) verdict_nxt = hfti_pkg::V_DONE;
            else lit_nxt = lit_r + 3'd1;
          end else begin
            verdict_nxt = hfti_pkg::V_FAIL;
          end
        end
        default: begin
          verdict_nxt = hfti_pkg::V_FAIL;
        end
      endcase
    end

    // a field that ends mid-grammar is good only inside the exponent part
    verdict_fin = verdict_nxt;
    if (verdict_nxt == hfti_pkg::V_OPEN) begin
      verdict_fin = (phase_nxt == hfti_pkg::PH_ESIGN || phase_nxt == hfti_pkg::PH_EDIG)
                    ? hfti_pkg::V_DONE : hfti_pkg::V_FAIL;
    end

    fin.dp       = dp;
    fin.fail     = (verdict_fin != hfti_pkg::V_DONE);
    fin.phase    = phase_nxt;
    fin.negative = neg_nxt;
    fin.lz       = lz_nxt;
    fin.frac     = frac_nxt;
    fin.ndig     = ndig_nxt;
    fin.eneg     = eneg_nxt;
    fin.eacc     = eacc_nxt;
    fin.count    = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && field_end)) begin
      phase_r   <= hfti_pkg::PH_START;
      verdict_r <= hfti_pkg::V_OPEN;
      neg_r     <= 1'b0;
      lz_r      <= 1'b0;
      frac_r    <= '0;
      ndig_r    <= '0;
      eneg_r    <= 1'b0;
      eacc_r    <= '0;
      lit_r     <= '0;
      count_r   <= '0;
    end else if (beat) begin
      phase_r   <= phase_nxt;
      verdict_r <= verdict_nxt;
      neg_r     <= neg_nxt;
      lz_r      <= lz_nxt;
      frac_r    <= frac_nxt;
      ndig_r    <= ndig_nxt;
      eneg_r    <= eneg_nxt;
      eacc_r    <= eacc_nxt;
      lit_r     <= lit_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hfti_pack.sv =====
// assembles the ieee bits, outcome and byte count from a finished field
`timescale 1ns / 1ps
`default_nettype none
module hfti_pack (
  input  hfti_pkg::hfti_fin_t fin,
  output logic [63:0]         value_bits,
  output hfti_pkg::outcome_t  outcome,
  output logic [7:0]          bytes_used
);

  logic [63:0] na;
  logic [5:0]  sh64;
  logic [4:0]  sh32;
  logic [51:0] frac64;
  logic [23:0] frac24;
  logic [51:0] frac_sel;
  logic        frac_nz;
  logic        too_many;
  logic [11:0] bias;
  logic [11:0] bexp;
  logic        num_ok;
  logic [63:0] num_bits;

  always_comb begin
    na     = fin.dp ? hfti_pkg::NA64 : hfti_pkg::NA32;
    sh64   = {4'(hfti_pkg::MAX_DIG64 - fin.ndig), 2'b00};
    sh32   = {3'(hfti_pkg::MAX_DIG32[2:0] - fin.ndig[2:0]), 2'b00};
    frac64 = fin.frac << sh64;
    frac24 = fin.frac[23:0] << sh32;
    frac_sel = fin.dp ? frac64 : {29'b0, frac24[23:1]};
    frac_nz  = |frac_sel;
    too_many = fin.dp ? (fin.ndig > hfti_pkg::MAX_DIG64) : (fin.ndig > hfti_pkg::MAX_DIG32);
    bias     = fin.dp ? hfti_pkg::BIAS64 : hfti_pkg::BIAS32;

    num_ok = !too_many;
    bexp   = '0;
    if (fin.lz) begin
      if (!((fin.eacc == '0 && !frac_nz) ||
            (fin.eacc == bias - 12'd1 && fin.eneg && frac_nz))) begin
        num_ok = 1'b0;
      end
    end else begin
      // negative exponent stays below the bias, positive one may reach it
      if (fin.eneg ? (fin.eacc >= bias) : (fin.eacc > bias)) num_ok = 1'b0;
      bexp = fin.eneg ? bias - fin.eacc : bias + fin.eacc;
    end

    if (fin.dp) num_bits = {fin.negative, bexp[10:0], frac_sel};
    else        num_bits = {32'b0, fin.negative, bexp[7:0], frac_sel[22:0]};

    value_bits = na;
    outcome    = hfti_pkg::OUT_MALFORMED;
    bytes_used = '0;
    if (!fin.fail) begin
      case (fin.phase)
        hfti_pkg::PH_NAN: begin
          outcome    = hfti_pkg::OUT_NAN;
          bytes_used = fin.count;
        end
        hfti_pkg::PH_INF: begin
          value_bits = fin.dp ? (hfti_pkg::INF64 | {fin.negative, 63'b0})
                              : (hfti_pkg::INF32 | {32'b0, fin.negative, 31'b0});
          outcome    = hfti_pkg::OUT_NUMBER;
          bytes_used = fin.count;
        end
        default: begin
          if (num_ok) begin
            value_bits = num_bits;
            outcome    = hfti_pkg::OUT_NUMBER;
            bytes_used = fin.count;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hex_float_text_to_ieee.sv =====
// top level: hex float text field parser with stream channels and apb register
//
// in channel: one ascii character per beat in in_tdata, in_tlast marks the
// last character of a field. out channel: one result beat per field, ieee
// bits and consumed byte count in out_tdata, outcome code in out_tuser.
// register 0 (byte address 0) selects float64 (1, reset value) or float32
// (0, bits in the low half); write it only while no field is in flight.
// throughput: one character per cycle with no gaps between fields, while
// in_tready is high. the character tracker updates its small state registers
// once per beat. the result of a field reaches out_tvalid through a capture
// register, which holds the finished field state, and then the output
// register, which holds the packed result.
// when out_tready is low the result stays in the output register and the
// next finished field waits in the capture register; while that capture
// slot is full and cannot move on, in_tready is low for every character.
// synchronous reset clears all field state, empties both result stages and
// sets the mode register to float64.
`timescale 1ns / 1ps
`default_nettype none
module hex_float_text_to_ieee #(
  parameter int MAX_FIELD_BYTES = hfti_pkg::MaxFieldBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] text_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,    // [63:0] value_bits, [71:64] bytes_used
  output logic [1:0]       out_tuser,    // [1:0] outcome
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic dp_r;
  logic in_beat;
  logic snap_load;
  logic out_load;
  logic snap_valid_r, snap_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  hfti_pkg::hfti_fin_t fin;
  hfti_pkg::hfti_fin_t snap_r;
  logic [63:0] value_bits;
  hfti_pkg::outcome_t outcome;
  logic [7:0]  bytes_used;
  logic [63:0] value_r;
  logic [1:0]  outcome_r;
  logic [7:0]  bytes_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'b0, dp_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      dp_r <= cfg_pwdata[0];
    end
  end

  assign out_load  = snap_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !snap_valid_r || out_load;
  assign in_beat   = in_tvalid && in_tready;
  assign snap_load = in_beat && in_tlast;

  hfti_scan #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (in_beat),
    .text_byte(in_tdata),
    .field_end(in_tlast),
    .dp       (dp_r),
    .fin      (fin)
  );

  hfti_pack u_pack (
    .fin       (snap_r),
    .value_bits(value_bits),
    .outcome   (outcome),
    .bytes_used(bytes_used)
  );

  always_comb begin
    snap_valid_nxt = snap_load ? 1'b1 : (out_load ? 1'b0 : snap_valid_r);
    out_valid_nxt  = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) snap_r <= fin;
    if (out_load) begin
      value_r   <= value_bits;
      outcome_r <= outcome;
      bytes_r   <= bytes_used;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bytes_r, value_r};
  assign out_tuser  = outcome_r;

endmodule
`default_nettype wire
